@@ sv/pbas_pkg.sv @@
package pbas_pkg;

  localparam int ADDR_W        = 32;
  localparam int COUNT_W       = 21;
  localparam int PAGE_POOL_DEF = 16;
  localparam int LOW_BITS_DEF  = 16;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
  } pbas_in_t;

  typedef struct packed {
    logic               was_member;
    logic               pool_full;
    logic [COUNT_W-1:0] member_count;
  } pbas_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } pbas_state_e;

endpackage

@@ sv/pbas_ram.sv @@
module pbas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/paged_bitmap_address_set_top.sv @@
// one request at a time: map read, bitmap read, bitmap write back
// result is registered from the bitmap read data; the next request waits until ST_UPDATE ends
// a new request is taken while the previous result still waits at the output
// reset is asynchronous; after it a clearing pass zeroes every address of both
// memories with in_ready_o low
module paged_bitmap_address_set_top
  import pbas_pkg::*;
#(
  parameter int PAGE_POOL = PAGE_POOL_DEF,
  parameter int LOW_BITS  = LOW_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pbas_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pbas_out_t out_data_o
);

  localparam int PFX_W  = ADDR_W - LOW_BITS;
  localparam int PG_W   = (PAGE_POOL > 1) ? $clog2(PAGE_POOL) : 1;
  localparam int NPG_W  = $clog2(PAGE_POOL + 1);
  localparam int BYTE_W = LOW_BITS - 3;
  localparam int BM_AW  = PG_W + BYTE_W;
  localparam int MAP_W  = PG_W + 1;
  localparam int CLR_W  = (PFX_W > BM_AW) ? PFX_W : BM_AW;
  localparam logic [NPG_W-1:0] POOL_N = NPG_W'(PAGE_POOL);

  pbas_state_e state_q, state_d;

  logic [CLR_W-1:0]   clr_q, clr_d;
  pbas_in_t           item_q;
  logic [NPG_W-1:0]   pages_q, pages_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               active_q, active_d;
  logic               full_q, full_d;
  logic [BM_AW-1:0]   bm_addr_q, bm_addr_d;
  pbas_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               map_we, map_re;
  logic [PFX_W-1:0]   map_waddr, map_raddr;
  logic [MAP_W-1:0]   map_wdata, map_rdata;
  logic               bm_we, bm_re;
  logic [BM_AW-1:0]   bm_waddr;
  logic [7:0]         bm_wdata, bm_rdata, bit_mask;

  logic               accept, out_free, is_add, hit, room, alloc, was, set_bit;
  logic [PG_W-1:0]    page_sel;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_add   = (item_q.mode == MODE_ADD);
  assign hit      = map_rdata[PG_W];
  assign room     = (pages_q < POOL_N);
  assign alloc    = !hit && is_add && room;
  assign page_sel = hit ? map_rdata[PG_W-1:0] : pages_q[PG_W-1:0];
  assign bit_mask = 8'h01 << item_q.address[2:0];
  assign was      = active_q && bm_rdata[item_q.address[2:0]];
  assign set_bit  = active_q && is_add && !was;

  pbas_ram #(
    .WIDTH (MAP_W),
    .DEPTH (1 << PFX_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  pbas_ram #(
    .WIDTH (8),
    .DEPTH (1 << BM_AW)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_addr_d),
    .rdata_o (bm_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    clr_d       = clr_q;
    pages_d     = pages_q;
    count_d     = count_q;
    active_d    = active_q;
    full_d      = full_q;
    bm_addr_d   = bm_addr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    map_we      = 1'b0;
    map_waddr   = item_q.address[ADDR_W-1:LOW_BITS];
    map_wdata   = {1'b1, pages_q[PG_W-1:0]};
    map_re      = 1'b0;
    map_raddr   = in_data_i.address[ADDR_W-1:LOW_BITS];
    bm_we       = 1'b0;
    bm_re       = 1'b0;
    bm_waddr    = bm_addr_q;
    bm_wdata    = bm_rdata | bit_mask;
    case (state_q)
      ST_CLEAR: begin
        clr_d     = clr_q + 1'b1;
        map_we    = 1'b1;
        map_waddr = clr_q[PFX_W-1:0];
        map_wdata = '0;
        bm_we     = 1'b1;
        bm_waddr  = clr_q[BM_AW-1:0];
        bm_wdata  = '0;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        map_re     = accept;
      end
      ST_LOOKUP: begin
        // a fresh page was zeroed by the clearing pass, so it reads back as zero
        active_d  = hit || alloc;
        full_d    = !hit && is_add && !room;
        bm_addr_d = {page_sel, item_q.address[LOW_BITS-1:3]};
        bm_re     = 1'b1;
        map_we    = alloc;
        if (alloc) pages_d = pages_q + 1'b1;
      end
      ST_UPDATE: begin
        if (out_free) begin
          bm_we       = set_bit;
          if (set_bit) count_d = count_q + 1'b1;
          out_d       = '{was_member:   was,
                          pool_full:    full_q,
                          member_count: set_bit ? count_q + 1'b1 : count_q};
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pages_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pages_q     <= pages_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    active_q  <= active_d;
    full_q    <= full_d;
    bm_addr_q <= bm_addr_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/pbas_checker.sv @@
module pbas_checker
  import pbas_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input pbas_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input pbas_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_full_not_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.was_member && out_data_o.pool_full))
    else $error("dropped add reported as member");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##3 out_valid_o)
    else $error("result missing after fixed latency");

endmodule

bind paged_bitmap_address_set_top pbas_checker u_pbas_checker (.*);

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbas_pkg::*;

  localparam int PAGE_POOL  = PAGE_POOL_DEF;
  localparam int LOW_BITS   = LOW_BITS_DEF;
  localparam int RAND_ITEMS = 1500;
  localparam int HOLD_AT    = 1000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_CYC  = 20;

  typedef struct packed {
    logic               has_answer;
    logic               mode;
    logic [ADDR_W-1:0]  address;
    logic               was_member;
    logic               pool_full;
    logic [COUNT_W-1:0] member_count;
  } dir_row_t;

  localparam int DIR_N = 27;

  // typed answers only on rows that follow from reset at a glance
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b1, MODE_TEST, 32'h0000_0000, 1'b0, 1'b0, 21'd0},
    '{1'b1, MODE_ADD,  32'h0000_0000, 1'b0, 1'b0, 21'd1},
    '{1'b1, MODE_ADD,  32'h0000_0000, 1'b1, 1'b0, 21'd1},
    '{1'b1, MODE_TEST, 32'h0000_0000, 1'b1, 1'b0, 21'd1},
    '{1'b0, MODE_ADD,  32'h0000_0001, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_TEST, 32'h0000_0001, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_TEST, 32'h0000_0002, 1'b0, 1'b0, 21'd0},
    '{1'b1, MODE_ADD,  32'hFFFF_FFFF, 1'b0, 1'b0, 21'd3},
    '{1'b0, MODE_ADD,  32'hFFFF_0000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_TEST, 32'hFFFF_FFFE, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0000_FFFF, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0001_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0002_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0003_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0004_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0005_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0006_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0007_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0008_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h0009_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h000A_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h000B_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h000C_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h000D_8000, 1'b0, 1'b0, 21'd0},
    '{1'b0, MODE_ADD,  32'h000E_8000, 1'b0, 1'b0, 21'd0},
    // pool now holds 16 pages, a new prefix is refused
    '{1'b1, MODE_ADD,  32'h1234_5678, 1'b0, 1'b1, 21'd19},
    '{1'b1, MODE_TEST, 32'h1234_5678, 1'b0, 1'b0, 21'd19}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  pbas_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  pbas_out_t out_data_o;

  paged_bitmap_address_set_top #(
    .PAGE_POOL(PAGE_POOL),
    .LOW_BITS (LOW_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the set: prefix -> page, and (page, offset) -> present
  int unsigned page_of_prefix [int unsigned];
  bit          bit_is_set     [int unsigned];
  int unsigned pages_taken;
  logic [31:0] members;

  pbas_out_t lookup_answers_q [$];
  int        mismatches;
  int        burst_left;

  function automatic pbas_out_t set_member_lookup(pbas_in_t req);
    pbas_out_t   rsp;
    int unsigned pfx;
    int unsigned offset;
    int unsigned key;
    rsp    = '0;
    pfx    = req.address >> LOW_BITS;
    offset = req.address & ((32'd1 << LOW_BITS) - 1);
    if (page_of_prefix.exists(pfx)) begin
      key = (page_of_prefix[pfx] << LOW_BITS) | offset;
      rsp.was_member = (bit_is_set.exists(key) != 0);
      if (req.mode == MODE_ADD && !rsp.was_member) begin
        bit_is_set[key] = 1'b1;
        members++;
      end
    end else if (req.mode == MODE_ADD) begin
      if (pages_taken < PAGE_POOL) begin
        page_of_prefix[pfx] = pages_taken;
        key = (pages_taken << LOW_BITS) | offset;
        pages_taken++;
        bit_is_set[key] = 1'b1;
        members++;
      end else begin
        rsp.pool_full = 1'b1;
      end
    end
    rsp.member_count = members[COUNT_W-1:0];
    return rsp;
  endfunction

  task automatic send_request(input pbas_in_t req, input logic use_typed,
                              input pbas_out_t typed_rsp);
    pbas_out_t predicted;
    int        gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = set_member_lookup(req);
    lookup_answers_q.push_back(use_typed ? typed_rsp : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    pbas_in_t    req;
    pbas_out_t   typed_rsp;
    logic [31:0] last_addr;
    int          pick;
    int          hot_idx;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    pages_taken = 0;
    members     = '0;
    mismatches  = 0;
    burst_left  = 1;
    last_addr   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      req.mode               = DIR_TAB[r].mode;
      req.address            = DIR_TAB[r].address;
      typed_rsp.was_member   = DIR_TAB[r].was_member;
      typed_rsp.pool_full    = DIR_TAB[r].pool_full;
      typed_rsp.member_count = DIR_TAB[r].member_count;
      send_request(req, DIR_TAB[r].has_answer, typed_rsp);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      req.mode = ($urandom_range(0, 9) < 6) ? MODE_ADD : MODE_TEST;
      pick     = $urandom_range(0, 9);
      if (pick < 6) begin
        // mapped prefixes, a few narrow offset windows so members repeat
        hot_idx            = $urandom_range(0, 15);
        req.address[31:16] = (hot_idx == 15) ? 16'hFFFF : hot_idx[15:0];
        req.address[15:0]  = {$urandom_range(0, 3) == 0 ? 8'hFF : 8'h00,
                              3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))};
      end else if (pick < 7) begin
        req.address = last_addr ^ 32'($urandom_range(0, 1));
      end else if (pick < 8) begin
        req.address = {16'h8000 | 16'($urandom_range(0, 7)), 16'($urandom)};
      end else begin
        req.address = $urandom;
      end
      last_addr = req.address;
      send_request(req, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (lookup_answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: changing stall styles plus one long hold-off
  initial begin
    int rx_cycles;
    int rx_style;
    bit rx_started;
    rx_cycles   = 0;
    rx_style    = 0;
    rx_started  = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o) rx_started = 1'b1;
      if (rx_started) rx_cycles++;
      if (rx_cycles % 50 == 0) rx_style = $urandom_range(0, 3);
      if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_LEN) begin
        out_ready_i <= 1'b0;
      end else begin
        case (rx_style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cycles % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    pbas_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lookup_answers_q.size() == 0) begin
        $display("%0t: unexpected response was_member=%0b pool_full=%0b count=%0d",
                 $time, out_data_o.was_member, out_data_o.pool_full,
                 out_data_o.member_count);
        mismatches++;
      end else begin
        want = lookup_answers_q.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: expected was_member=%0b pool_full=%0b count=%0d, got %0b %0b %0d",
                   $time, want.was_member, want.pool_full, want.member_count,
                   out_data_o.was_member, out_data_o.pool_full,
                   out_data_o.member_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
